[rtl/table_linear_interpolator_defines.svh]
// assertion macros shared by the table interpolator rtl
// no dependencies; included by the top level
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// implication checked on every rising edge outside reset
`define TLI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication outside reset
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tli_pkg.sv]
// shared types and constants for the table interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tli_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_EQ_WAIT, S_LO_START, S_LO_WAIT, S_HI_START,
    S_HI_WAIT, S_MUL, S_OFF_START, S_OFF_WAIT, S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // latch request fields
    logic do_clear;
    logic do_append;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic [1:0] div_sel; // 0 eq mean, 1 lo mean, 2 hi mean, 3 offset
    logic do_mul;
    logic finish;     // compute final value/status
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic op_query;
    logic op_append;
    logic op_clear;
    logic query_ok;   // table not empty and point in range
    logic eq_found;
    logic bracket;    // lo and hi both found
  } stat_t;

  localparam logic [1:0] DivEq  = 2'd0;
  localparam logic [1:0] DivLo  = 2'd1;
  localparam logic [1:0] DivHi  = 2'd2;
  localparam logic [1:0] DivOff = 2'd3;
endpackage
`default_nettype wire

[rtl/tli_div.sv]
// iterative unsigned divider, one quotient bit per cycle
// depends on nothing but its ports
`timescale 1ns / 1ps
`default_nettype none
module tli_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  // restoring shift-subtract step
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = '0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, quo_r[63]} - {1'b0, divisor};
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = busy_r && (cnt_r == 7'd1);
  assign quotient = quo_nxt;
endmodule
`default_nettype wire

[rtl/tli_datapath.sv]
// table memories, scan accumulators, divider and result registers
// depends on tli_pkg and tli_div
`timescale 1ns / 1ps
`default_nettype none
module tli_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tli_pkg::cmd_t       cmd,
  output tli_pkg::stat_t           stat,
  input  wire logic [1:0]          in_op,
  input  wire logic signed [31:0]  in_key,
  input  wire logic signed [31:0]  in_val,
  input  wire logic signed [31:0]  in_query,
  output logic [1:0]               res_status,
  output logic signed [31:0]       res_value,
  output logic [tli_pkg::CntW-1:0] res_count
);
  localparam int IdxW = tli_pkg::IdxW;
  localparam int CntW = tli_pkg::CntW;

  logic [31:0] key_mem [tli_pkg::TableDepth];
  logic [31:0] val_mem [tli_pkg::TableDepth];

  logic [1:0]         op_r;
  logic signed [31:0] key_r, val_r, q_r;
  logic [CntW-1:0]    fill_r;
  logic               drop_r;
  logic signed [31:0] lowk_r, highk_r;
  logic [CntW-1:0]    idx_r;
  logic               rd_vld_r;
  logic signed [31:0] rk_r, rv_r;

  logic signed [63:0] eq_sum_r, lo_sum_r, hi_sum_r;
  logic [CntW-1:0]    eq_cnt_r, lo_cnt_r, hi_cnt_r;
  logic signed [31:0] lo_key_r, hi_key_r;
  logic signed [63:0] mean_eq_r, mlo_r, mhi_r, off_r;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] value_r, value_nxt;

  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_q;
  logic signed [63:0] sum_sel;
  logic [CntW-1:0]    cnt_sel;
  logic               sum_neg;
  logic signed [63:0] signed_q, dv, res64;
  logic [63:0]        mag;
  logic [32:0]        dq33;
  logic [65:0]        prod_full;
  logic               query_ok, scan_done;

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.do_append && fill_r != CntW'(tli_pkg::TableDepth)) begin
      key_mem[fill_r[IdxW-1:0]] <= key_r;
      val_mem[fill_r[IdxW-1:0]] <= val_r;
    end
    rk_r <= key_mem[idx_r[IdxW-1:0]];
    rv_r <= val_mem[idx_r[IdxW-1:0]];
  end

  // request latch, fill count and key extremes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      op_r   <= tli_pkg::OP_NONE;
      drop_r <= 1'b0;
    end else begin
      if (cmd.accept) op_r <= in_op;
      if (cmd.do_append) drop_r <= fill_r == CntW'(tli_pkg::TableDepth);
      if (cmd.do_clear) fill_r <= '0;
      else if (cmd.do_append && fill_r != CntW'(tli_pkg::TableDepth))
        fill_r <= fill_r + CntW'(1);
    end
    if (cmd.accept) begin
      key_r <= in_key;
      val_r <= in_val;
      q_r   <= in_query;
    end
    if (cmd.do_append && fill_r != CntW'(tli_pkg::TableDepth)) begin
      if (fill_r == '0 || key_r < lowk_r)  lowk_r  <= key_r;
      if (fill_r == '0 || key_r > highk_r) highk_r <= key_r;
    end
  end

  // scan: address runs one ahead of the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_vld_r <= idx_r < fill_r;
      if (idx_r < fill_r) idx_r <= idx_r + CntW'(1);
    end
  end

  // equal, below and above accumulators
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      eq_cnt_r <= '0;
      lo_cnt_r <= '0;
      hi_cnt_r <= '0;
      eq_sum_r <= '0;
      lo_sum_r <= '0;
      hi_sum_r <= '0;
      lo_key_r <= '0;
      hi_key_r <= '0;
    end else if (cmd.scan_step && rd_vld_r) begin
      if (rk_r == q_r) begin
        eq_sum_r <= eq_sum_r + 64'(rv_r);
        eq_cnt_r <= eq_cnt_r + CntW'(1);
      end else if (rk_r < q_r) begin
        if (lo_cnt_r == '0 || rk_r > lo_key_r) begin
          lo_key_r <= rk_r;
          lo_sum_r <= 64'(rv_r);
          lo_cnt_r <= CntW'(1);
        end else if (rk_r == lo_key_r) begin
          lo_sum_r <= lo_sum_r + 64'(rv_r);
          lo_cnt_r <= lo_cnt_r + CntW'(1);
        end
      end else begin
        if (hi_cnt_r == '0 || rk_r < hi_key_r) begin
          hi_key_r <= rk_r;
          hi_sum_r <= 64'(rv_r);
          hi_cnt_r <= CntW'(1);
        end else if (rk_r == hi_key_r) begin
          hi_sum_r <= hi_sum_r + 64'(rv_r);
          hi_cnt_r <= hi_cnt_r + CntW'(1);
        end
      end
    end
  end

  // divider operand selection: signed means by magnitude, or slope product over key span
  always_comb begin
    sum_sel = eq_sum_r;
    cnt_sel = eq_cnt_r;
    case (cmd.div_sel)
      tli_pkg::DivLo: begin sum_sel = lo_sum_r; cnt_sel = lo_cnt_r; end
      tli_pkg::DivHi: begin sum_sel = hi_sum_r; cnt_sel = hi_cnt_r; end
      default: begin sum_sel = eq_sum_r; cnt_sel = eq_cnt_r; end
    endcase
    sum_neg = sum_sel[63];
    if (cmd.div_sel == tli_pkg::DivOff) begin
      div_a = prod_r;
      div_b = 64'(64'(hi_key_r) - 64'(lo_key_r));
    end else begin
      div_a = sum_neg ? 64'(-sum_sel) : 64'(sum_sel);
      div_b = 64'(cnt_sel);
    end
  end

  assign div_start = cmd.div_start;

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // capture quotients, slope product and offset
  assign signed_q  = sum_neg ? -$signed(div_q) : $signed(div_q);
  assign dv        = mhi_r - mlo_r;
  assign mag       = dv[63] ? 64'(-dv) : 64'(dv);
  // means differ by at most 33 bits, point offset by 32 bits
  assign dq33      = 33'(64'(q_r) - 64'(lo_key_r));
  assign prod_full = mag[32:0] * dq33;

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        tli_pkg::DivEq: mean_eq_r <= signed_q;
        tli_pkg::DivLo: mlo_r     <= signed_q;
        tli_pkg::DivHi: mhi_r     <= signed_q;
        default:        off_r     <= $signed(div_q);
      endcase
    end
    if (cmd.do_mul) begin
      prod_r <= prod_full[63:0];
      neg_r  <= dv[63];
    end
  end

  assign res64 = neg_r ? mlo_r - off_r : mlo_r + off_r;

  // final status and saturated value
  always_comb begin
    status_nxt = tli_pkg::ST_OK;
    value_nxt  = '0;
    if (op_r == tli_pkg::OP_APPEND) begin
      if (drop_r) status_nxt = tli_pkg::ST_FULL;
    end else if (op_r == tli_pkg::OP_QUERY) begin
      if (fill_r == '0) status_nxt = tli_pkg::ST_EMPTY;
      else if (!query_ok) status_nxt = tli_pkg::ST_RANGE;
      else if (eq_cnt_r != '0) value_nxt = mean_eq_r[31:0];
      else if (lo_cnt_r != '0 && hi_cnt_r != '0) begin
        if (res64 > 64'sd2147483647) value_nxt = 32'sh7fffffff;
        else if (res64 < -64'sd2147483648) value_nxt = 32'sh80000000;
        else value_nxt = res64[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  // status toward the controller
  assign query_ok  = fill_r != '0 && !(q_r < lowk_r) && !(q_r > highk_r);
  assign scan_done = cmd.scan_step && rd_vld_r == 1'b0 && idx_r == fill_r;

  always_comb begin
    stat.scan_done = scan_done;
    stat.div_done  = div_done;
    stat.op_query  = op_r == tli_pkg::OP_QUERY;
    stat.op_append = op_r == tli_pkg::OP_APPEND;
    stat.op_clear  = op_r == tli_pkg::OP_CLEAR;
    stat.query_ok  = query_ok;
    stat.eq_found  = eq_cnt_r != '0;
    stat.bracket   = lo_cnt_r != '0 && hi_cnt_r != '0;
  end

  assign res_status = status_r;
  assign res_value  = value_r;
  assign res_count  = fill_r;
endmodule
`default_nettype wire

[rtl/tli_ctrl.sv]
// controller state machine sequencing scan, divisions and output
// depends on tli_pkg
`timescale 1ns / 1ps
`default_nettype none
module tli_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output tli_pkg::cmd_t       cmd,
  input  wire tli_pkg::stat_t stat
);
  tli_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tli_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tli_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tli_pkg::S_DECODE;
        end
      end
      tli_pkg::S_DECODE: begin
        // dispatch by request kind
        if (stat.op_clear) begin
          cmd.do_clear = 1'b1;
          state_nxt = tli_pkg::S_FINISH;
        end else if (stat.op_append) begin
          cmd.do_append = 1'b1;
          state_nxt = tli_pkg::S_FINISH;
        end else if (stat.op_query && stat.query_ok) begin
          cmd.scan_start = 1'b1;
          state_nxt = tli_pkg::S_SCAN;
        end else begin
          state_nxt = tli_pkg::S_FINISH;
        end
      end
      tli_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          // exact match needs only the equal mean
          if (stat.eq_found) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tli_pkg::DivEq;
            state_nxt = tli_pkg::S_EQ_WAIT;
          end else if (stat.bracket) begin
            state_nxt = tli_pkg::S_LO_START;
          end else begin
            state_nxt = tli_pkg::S_FINISH;
          end
        end
      end
      tli_pkg::S_EQ_WAIT: begin
        cmd.div_sel = tli_pkg::DivEq;
        if (stat.div_done) state_nxt = tli_pkg::S_FINISH;
      end
      tli_pkg::S_LO_START: begin
        cmd.div_sel   = tli_pkg::DivLo;
        cmd.div_start = 1'b1;
        state_nxt = tli_pkg::S_LO_WAIT;
      end
      tli_pkg::S_LO_WAIT: begin
        cmd.div_sel = tli_pkg::DivLo;
        if (stat.div_done) state_nxt = tli_pkg::S_HI_START;
      end
      tli_pkg::S_HI_START: begin
        cmd.div_sel   = tli_pkg::DivHi;
        cmd.div_start = 1'b1;
        state_nxt = tli_pkg::S_HI_WAIT;
      end
      tli_pkg::S_HI_WAIT: begin
        cmd.div_sel = tli_pkg::DivHi;
        if (stat.div_done) state_nxt = tli_pkg::S_MUL;
      end
      tli_pkg::S_MUL: begin
        // slope product from both means
        cmd.do_mul = 1'b1;
        state_nxt = tli_pkg::S_OFF_START;
      end
      tli_pkg::S_OFF_START: begin
        cmd.div_sel   = tli_pkg::DivOff;
        cmd.div_start = 1'b1;
        state_nxt = tli_pkg::S_OFF_WAIT;
      end
      tli_pkg::S_OFF_WAIT: begin
        cmd.div_sel = tli_pkg::DivOff;
        if (stat.div_done) state_nxt = tli_pkg::S_FINISH;
      end
      tli_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = tli_pkg::S_IDLE;
      end
      default: state_nxt = tli_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/table_linear_interpolator.sv]
// Table linear interpolator, top level.
// Depends on tli_pkg, tli_ctrl, tli_datapath, table_linear_interpolator_defines.svh.
//
// Requests enter on the in_ stream (op, sample key/value, query point); each
// request yields exactly one result on the out_ stream (status, value, count).
// out_tvalid rises after the decode and finish states for clear, append, the
// unused op and a query that is empty or out of range. A query reads every
// held sample from the table memory at one entry per cycle; an exact key
// match then runs one shift-subtract division, otherwise three divisions run
// on the shared divider (lower mean, upper mean, slope offset).
// One request is in flight at a time; in_tready is high only while the block
// is waiting for a request and no result is held, so the next request is
// taken, at the earliest, in the cycle after the result leaves.
// The result sits in an output register until out_tready takes it; while the
// receiver stalls no new request is taken.
// Reset empties the table (count zero); the table memory itself is not
// cleared, no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "table_linear_interpolator_defines.svh"
module table_linear_interpolator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [1:0] op, [33:2] sample_key, [65:34] sample_value, [97:66] query_point
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [1:0] status, [33:2] interp_value, [42:34] entry_count
  output logic [47:0]       out_tdata
);
  tli_pkg::cmd_t  cmd;
  tli_pkg::stat_t stat;
  logic ctrl_ready, ovld_r;
  logic [1:0]  res_status;
  logic signed [31:0] res_value;
  logic [tli_pkg::CntW-1:0] res_count;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid && !ovld_r),
    .in_ready  (ctrl_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tli_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tdata[1:0]),
    .in_key     (in_tdata[33:2]),
    .in_val     (in_tdata[65:34]),
    .in_query   (in_tdata[97:66]),
    .res_status (res_status),
    .res_value  (res_value),
    .res_count  (res_count)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (cmd.finish) ovld_r <= 1'b1;
    else if (out_tready) ovld_r <= 1'b0;
  end

  assign in_tready  = ctrl_ready && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {5'd0, res_count, res_value, res_status};

  `TLI_ASSERT_IMPL(a_no_take_while_full, out_tvalid, !in_tready, "request taken while result held")
  `TLI_ASSERT_NEXT(a_finish_shows, cmd.finish, out_tvalid, "finished result not presented")
  `TLI_ASSERT_IMPL(a_count_bound, 1'b1, res_count <= 9'd256, "entry count above depth")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// testbench for the table linear interpolator: random and directed table loads and queries
// depends on tli_pkg and table_linear_interpolator; checks every result against its own predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
  typedef struct packed {
    tli_pkg::op_t op;
    logic [31:0]  skey;
    logic [31:0]  sval;
    logic [31:0]  qpt;
  } req_t;

  typedef struct packed {
    tli_pkg::status_t status;
    logic [31:0]      value;
    logic [8:0]       count;
  } res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [103:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;

  table_linear_interpolator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic signed [31:0] tbl_key [tli_pkg::TableDepth];
  logic signed [31:0] tbl_val [tli_pkg::TableDepth];
  int unsigned tbl_fill;
  logic signed [31:0] key_min, key_max;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   mismatches;
  int   send_idle_pct, recv_stall_pct;
  int   hold_cycles;
  bit   in_taken;
  longint cycles;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // mean over equal keys, else bracket interpolation
  function automatic logic [31:0] interpolate_at(logic signed [31:0] q);
    longint eq_sum, lo_sum, hi_sum, mlo, mhi, dv, res;
    int eq_n, lo_n, hi_n;
    logic signed [31:0] lo_k, hi_k, k;
    logic [63:0] dq, dk, mag, off;
    logic [127:0] prod;
    eq_sum = 0; lo_sum = 0; hi_sum = 0; eq_n = 0; lo_n = 0; hi_n = 0;
    lo_k = 0; hi_k = 0;
    for (int i = 0; i < tbl_fill; i++) begin
      k = tbl_key[i];
      if (k == q) begin
        eq_sum += longint'(tbl_val[i]); eq_n++;
      end else if (k < q) begin
        if (lo_n == 0 || k > lo_k) begin
          lo_k = k; lo_sum = longint'(tbl_val[i]); lo_n = 1;
        end else if (k == lo_k) begin
          lo_sum += longint'(tbl_val[i]); lo_n++;
        end
      end else begin
        if (hi_n == 0 || k < hi_k) begin
          hi_k = k; hi_sum = longint'(tbl_val[i]); hi_n = 1;
        end else if (k == hi_k) begin
          hi_sum += longint'(tbl_val[i]); hi_n++;
        end
      end
    end
    if (eq_n > 0) return 32'(clamp32(eq_sum / eq_n));
    if (lo_n == 0 || hi_n == 0) return 32'd0;
    mlo = lo_sum / lo_n;
    mhi = hi_sum / hi_n;
    dv = mhi - mlo;
    dq = 64'(longint'(q) - longint'(lo_k));
    dk = 64'(longint'(hi_k) - longint'(lo_k));
    mag = (dv < 0) ? 64'(-dv) : 64'(dv);
    prod = 128'(dq) * 128'(mag);
    off = (dk != 0) ? 64'(prod / 128'(dk)) : 64'd0;
    res = (dv < 0) ? mlo - longint'(off) : mlo + longint'(off);
    return 32'(clamp32(res));
  endfunction

  function automatic res_t apply_request(req_t r);
    res_t o;
    o.status = tli_pkg::ST_OK;
    o.value = 32'd0;
    case (r.op)
      tli_pkg::OP_CLEAR: tbl_fill = 0;
      tli_pkg::OP_APPEND: begin
        if (tbl_fill >= tli_pkg::TableDepth) begin
          o.status = tli_pkg::ST_FULL;
        end else begin
          tbl_key[tbl_fill] = r.skey;
          tbl_val[tbl_fill] = r.sval;
          if (tbl_fill == 0) begin
            key_min = r.skey; key_max = r.skey;
          end else begin
            if ($signed(r.skey) < key_min) key_min = r.skey;
            if ($signed(r.skey) > key_max) key_max = r.skey;
          end
          tbl_fill++;
        end
      end
      tli_pkg::OP_QUERY: begin
        if (tbl_fill == 0) o.status = tli_pkg::ST_EMPTY;
        else if ($signed(r.qpt) < key_min || $signed(r.qpt) > key_max)
          o.status = tli_pkg::ST_RANGE;
        else o.value = interpolate_at(r.qpt);
      end
      default: ;
    endcase
    o.count = 9'(tbl_fill);
    return o;
  endfunction

  // append one request to the pending queue
  task automatic enqueue(req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  // driver: offers the head of the pending queue at falling edges
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the offered request
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {6'd0, pending_reqs[0].qpt, pending_reqs[0].sval,
                    pending_reqs[0].skey, pending_reqs[0].op};
      void'(pending_reqs.pop_front());
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver ready, with a long hold-off counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin
    res_t got, exp_r;
    req_t acc;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        acc.op = tli_pkg::op_t'(in_tdata[1:0]);
        acc.skey = in_tdata[33:2];
        acc.sval = in_tdata[65:34];
        acc.qpt = in_tdata[97:66];
        expected_results = {expected_results, apply_request(acc)};
      end
      if (out_tvalid && out_tready) begin
        got.status = tli_pkg::status_t'(out_tdata[1:0]);
        got.value = out_tdata[33:2];
        got.count = out_tdata[42:34];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d value %h count %0d, got status %0d value %h count %0d",
                       exp_r.status, exp_r.value, exp_r.count, got.status, got.value, got.count);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd5000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(8)) << 16;
      3: return -(32'($urandom_range(8)) << 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t mk(tli_pkg::op_t op, logic [31:0] k, logic [31:0] v,
                              logic [31:0] q);
    req_t r;
    r.op = op; r.skey = k; r.sval = v; r.qpt = q;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // one random table episode: clear, n_app appends, then n_q queries or unused ops
  task automatic push_episode(int n_app, int n_q, bit narrow);
    logic [31:0] k, v;
    enqueue(mk(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom()));
    for (int i = 0; i < n_app; i++) begin
      k = narrow ? 32'($signed($urandom_range(40)) - 20) << 14 : rand_word();
      v = narrow ? $urandom() >> $urandom_range(31) : rand_word();
      if ($urandom_range(1)) v = -v;
      enqueue(mk(tli_pkg::OP_APPEND, k, v, $urandom()));
    end
    for (int i = 0; i < n_q; i++) begin
      k = narrow ? 32'($signed($urandom_range(48)) - 24) << 14 : rand_word();
      if ($urandom_range(9) == 0) k = $urandom();
      enqueue(mk(tli_pkg::op_t'($urandom_range(9) == 0 ? tli_pkg::OP_NONE
                                                         : tli_pkg::OP_QUERY),
                 $urandom(), $urandom(), k));
    end
  endtask

  initial begin
    int phase_n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    tbl_fill = 0;
    key_min = 0;
    key_max = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty query, extremes, equal keys, duplicates in brackets, unused op
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 0));
    enqueue(mk(tli_pkg::OP_NONE, '1, '1, '1));
    enqueue(mk(tli_pkg::OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, 0));
    enqueue(mk(tli_pkg::OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, 0));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h0000_0000));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h8000_0000));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h7fff_ffff));
    enqueue(mk(tli_pkg::OP_APPEND, 32'h0001_0000, 32'h7fff_ffff, 0));
    enqueue(mk(tli_pkg::OP_APPEND, 32'h0001_0000, 32'h7fff_fffd, 0));
    enqueue(mk(tli_pkg::OP_APPEND, 32'h0001_0000, 32'h7fff_ffff, 0));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h0001_0000));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h0000_8000));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h4000_0000));
    enqueue(mk(tli_pkg::OP_CLEAR, 0, 0, 0));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 0));
    enqueue(mk(tli_pkg::OP_APPEND, 32'h0002_0000, 32'h0003_0000, 0));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h0001_0000));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h0003_0000));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, 32'h0002_0000));
    // fill to the top, then overflow
    enqueue(mk(tli_pkg::OP_CLEAR, 0, 0, 0));
    for (int i = 0; i < tli_pkg::TableDepth; i++)
      enqueue(mk(tli_pkg::OP_APPEND, $urandom(), $urandom(), 0));
    enqueue(mk(tli_pkg::OP_APPEND, '1, '1, 0));
    enqueue(mk(tli_pkg::OP_QUERY, 0, 0, $urandom()));
    wait_drained();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 34 : 0;
      phase_n = 0;
      while (phase_n < 400) begin
        int na, nq;
        na = ($urandom_range(19) == 0) ? $urandom_range(200, 270) : $urandom_range(1, 12);
        nq = $urandom_range(2, 10);
        push_episode(na, nq, $urandom_range(3) != 0);
        phase_n += na + nq + 1;
        if (ph == 0 && phase_n > 200 && hold_cycles == 0) hold_cycles = 3000;
      end
      wait_drained();
    end

    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
